### src/trse_pkg.sv
// ----------------------------------------------------------------------------
// Tri-state remote switch encoder package
// Shared constants, item types and the code word builder.
// ----------------------------------------------------------------------------
package trse_pkg;

  // Code word geometry
  localparam int GROUP_BITS = 5;
  localparam int CHAN_COUNT = 5;
  localparam int WORD_BITS  = 12;
  localparam logic [3:0] SYMBOLS = 4'd12;

  // Pulse units of the sync low phase
  localparam logic [4:0] SYNC_LONG  = 5'd31;
  localparam logic [4:0] SYNC_SHORT = 5'd10;

  // Register reset values
  localparam logic [9:0] PULSE_RESET  = 10'd350;
  localparam logic [5:0] REPEAT_RESET = 6'd10;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_PROTOCOL = 2'd2;

  // Request kinds
  localparam logic REQ_CMD  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Live configuration
  typedef struct packed {
    logic [9:0] pulse_length;
    logic [5:0] repeat_count;
    logic       sync_protocol;
  } trse_cfg_t;

  // Classified item held in the queue
  typedef struct packed {
    logic                 is_tick;
    logic                 chan_ok;
    logic [WORD_BITS-1:0] word;
  } trse_item_t;

  // Build the code word: bit 11 is the first symbol, 1 = 'F', 0 = '0'
  function automatic logic [WORD_BITS-1:0] build_word(
    input logic [GROUP_BITS-1:0] group,
    input logic [2:0]            chan,
    input logic                  on
  );
    logic [GROUP_BITS-1:0] grp_sym;
    logic [CHAN_COUNT-1:0] chan_sym;
    logic [1:0]            stat_sym;
    begin
      grp_sym = ~group;
      for (int i = 0; i < CHAN_COUNT; i++) begin
        chan_sym[CHAN_COUNT-1-i] = (chan != 3'(i + 1));
      end
      stat_sym = on ? 2'b01 : 2'b10;
      return {grp_sym, chan_sym, stat_sym};
    end
  endfunction

endpackage

### src/trse_if.sv
// ----------------------------------------------------------------------------
// Tri-state remote switch encoder channels
// Command and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface trse_cmd_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [4:0] group_switches;
  logic [2:0] channel;
  logic       turn_on;

  modport source (output valid, req_type, group_switches, channel, turn_on,
                  input ready);
  modport sink   (input valid, req_type, group_switches, channel, turn_on,
                  output ready);
endinterface

interface trse_res_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic busy_res;
  logic rejected;

  modport source (output valid, pin_level, busy_res, rejected, input ready);
  modport sink   (input valid, pin_level, busy_res, rejected, output ready);
endinterface

### src/trse_front.sv
// ----------------------------------------------------------------------------
// Tri-state remote switch encoder front end
// Accepts command and tick transfers, checks the channel, builds the word.
// ----------------------------------------------------------------------------
module trse_front
  import trse_pkg::*;
(
  trse_cmd_if.sink   cmd,
  input  logic       q_ready,
  output logic       q_valid,
  output trse_item_t q_item
);

  // Pass the handshake straight to the queue
  assign q_valid   = cmd.valid;
  assign cmd.ready = q_ready;

  // Classify the transfer
  always_comb begin
    q_item.is_tick = (cmd.req_type == REQ_TICK);
    q_item.chan_ok = (cmd.channel >= 3'd1) && (cmd.channel <= 3'(CHAN_COUNT));
    q_item.word    = build_word(cmd.group_switches, cmd.channel, cmd.turn_on);
  end

endmodule

### src/trse_queue.sv
// ----------------------------------------------------------------------------
// Tri-state remote switch encoder item queue
// Two-entry queue between front end and waveform engine.
// ----------------------------------------------------------------------------
module trse_queue
  import trse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  trse_item_t in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output trse_item_t out_item
);

  trse_item_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = entry[rd_ptr];

  // Store a pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### src/trse_back.sv
// ----------------------------------------------------------------------------
// Tri-state remote switch encoder waveform engine
// Carries out commands and ticks and holds the result register.
// ----------------------------------------------------------------------------
module trse_back
  import trse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  trse_cfg_t  cfg,
  input  logic       q_valid,
  output logic       q_ready,
  input  trse_item_t q_item,
  trse_res_if.source res
);

  // Transmission state
  logic [WORD_BITS-1:0] code_word;
  logic [3:0]           symbol_index;
  logic [1:0]           phase_index;
  logic [14:0]          tick_count;
  logic [5:0]           repeats_left;
  logic                 active;

  logic [WORD_BITS-1:0] code_word_next;
  logic [3:0]           symbol_index_next;
  logic [1:0]           phase_index_next;
  logic [14:0]          tick_count_next;
  logic [5:0]           repeats_left_next;
  logic                 active_next;

  // Result register
  logic out_valid;
  logic out_pin;
  logic out_busy;
  logic out_rej;
  logic pin_next;
  logic busy_next;
  logic rej_next;

  logic        pop;
  logic        in_sync;
  logic        sym_is_f;
  logic [3:0]  bit_sel;
  logic [4:0]  units;
  logic [14:0] len_raw;
  logic [14:0] len;
  logic [14:0] tick_inc;
  logic        phase_done;

  // Take an item when the result register is free or being drained
  assign q_ready = !out_valid || res.ready;
  assign pop     = q_valid && q_ready;

  assign res.valid     = out_valid;
  assign res.pin_level = out_pin;
  assign res.busy_res  = out_busy;
  assign res.rejected  = out_rej;

  // Units in the current phase; even phases are high, odd are low
  assign in_sync  = (symbol_index >= SYMBOLS);
  assign bit_sel  = 4'(WORD_BITS - 1) - symbol_index;
  assign sym_is_f = in_sync ? 1'b0 : code_word[bit_sel];

  always_comb begin
    if (in_sync) begin
      if (phase_index == 2'd0) units = 5'd1;
      else units = cfg.sync_protocol ? SYNC_SHORT : SYNC_LONG;
    end else begin
      case (phase_index)
        2'd0:    units = 5'd1;
        2'd1:    units = 5'd3;
        2'd2:    units = sym_is_f ? 5'd3 : 5'd1;
        2'd3:    units = sym_is_f ? 5'd1 : 5'd3;
        default: units = 5'd1;
      endcase
    end
  end

  // Phase length in ticks, at least one
  assign len_raw    = {10'd0, units} * {5'd0, cfg.pulse_length};
  assign len        = (len_raw == 15'd0) ? 15'd1 : len_raw;
  assign tick_inc   = tick_count + 15'd1;
  assign phase_done = (tick_inc >= len);

  // Next state and result for the popped item
  always_comb begin
    code_word_next    = code_word;
    symbol_index_next = symbol_index;
    phase_index_next  = phase_index;
    tick_count_next   = tick_count;
    repeats_left_next = repeats_left;
    active_next       = active;
    pin_next          = 1'b0;
    busy_next         = active;
    rej_next          = 1'b0;
    if (!q_item.is_tick) begin
      if (active || !q_item.chan_ok) begin
        rej_next = 1'b1;
      end else begin
        code_word_next    = q_item.word;
        symbol_index_next = 4'd0;
        phase_index_next  = 2'd0;
        tick_count_next   = 15'd0;
        repeats_left_next = (cfg.repeat_count == 6'd0) ? 6'd1 : cfg.repeat_count;
        active_next       = 1'b1;
        busy_next         = 1'b1;
      end
    end else if (active) begin
      pin_next        = !phase_index[0];
      tick_count_next = tick_inc;
      if (phase_done) begin
        tick_count_next = 15'd0;
        if (in_sync) begin
          if (phase_index == 2'd0) begin
            phase_index_next = 2'd1;
          end else begin
            phase_index_next  = 2'd0;
            symbol_index_next = 4'd0;
            repeats_left_next = repeats_left - 6'd1;
            if (repeats_left == 6'd1) active_next = 1'b0;
          end
        end else if (phase_index == 2'd3) begin
          phase_index_next  = 2'd0;
          symbol_index_next = symbol_index + 4'd1;
        end else begin
          phase_index_next = phase_index + 2'd1;
        end
      end
    end
  end

  // Update transmission state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      code_word    <= '0;
      symbol_index <= 4'd0;
      phase_index  <= 2'd0;
      tick_count   <= 15'd0;
      repeats_left <= 6'd0;
      active       <= 1'b0;
    end else if (pop) begin
      code_word    <= code_word_next;
      symbol_index <= symbol_index_next;
      phase_index  <= phase_index_next;
      tick_count   <= tick_count_next;
      repeats_left <= repeats_left_next;
      active       <= active_next;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_pin  <= pin_next;
      out_busy <= busy_next;
      out_rej  <= rej_next;
    end
  end

  // Checks
  a_sym_range: assert property (@(posedge clk) disable iff (rst)
    symbol_index <= SYMBOLS)
    else $error("symbol index beyond sync");

  a_sync_phase: assert property (@(posedge clk) disable iff (rst)
    (symbol_index == SYMBOLS) |-> (phase_index <= 2'd1))
    else $error("sync pulse has more than two phases");

  a_repeats: assert property (@(posedge clk) disable iff (rst)
    active |-> (repeats_left != 6'd0))
    else $error("active with no repetitions left");

  a_rej_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_rej) |-> !out_pin)
    else $error("refused command drives the pin");

  a_cmd_busy: assert property (@(posedge clk) disable iff (rst)
    (pop && !q_item.is_tick && q_item.chan_ok && !active) |=> active)
    else $error("accepted command did not start a transmission");

endmodule

### src/tristate_remote_switch_encoder.sv
// ----------------------------------------------------------------------------
// Tri-state remote switch encoder
// Builds a 12-symbol tri-state code word and drives the radio data pin.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                   transfer
//  cmd      in   req_type, group_switches, channel, turn_on valid & ready
//  res      out  pin_level, busy_res, rejected             valid & ready
//  cfg      in   cfg_index, cfg_data                       cfg_we
//
//  One item per clock sustained while results are taken. A result passes
//  through the item queue and then the result register before its
//  transfer. The waveform engine's per-item update (one 5x10 multiply
//  and a 15-bit compare) sets that rate. Reset (rst, synchronous) empties
//  the queue, stops any transmission and loads the register defaults. A
//  stalled result holds; the queue keeps accepting until two items wait.
// ----------------------------------------------------------------------------
module tristate_remote_switch_encoder
  import trse_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  trse_cmd_if.sink              cmd,
  trse_res_if.source            res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  trse_cfg_t  cfg;
  logic       fq_valid;
  logic       fq_ready;
  trse_item_t fq_item;
  logic       qb_valid;
  logic       qb_ready;
  trse_item_t qb_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_length  <= PULSE_RESET;
      cfg.repeat_count  <= REPEAT_RESET;
      cfg.sync_protocol <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PULSE_LENGTH:  cfg.pulse_length  <= cfg_data;
        REG_REPEAT_COUNT:  cfg.repeat_count  <= cfg_data[5:0];
        REG_SYNC_PROTOCOL: cfg.sync_protocol <= cfg_data[0];
        default: ;
      endcase
    end
  end

  trse_front u_front (
    .cmd     (cmd),
    .q_ready (fq_ready),
    .q_valid (fq_valid),
    .q_item  (fq_item)
  );

  trse_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_item   (fq_item),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_item  (qb_item)
  );

  trse_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (qb_valid),
    .q_ready (qb_ready),
    .q_item  (qb_item),
    .res     (res)
  );

endmodule
